/* rtl/rspl_pkg.sv */
// shared types and constants for the resampling sample player
`timescale 1ns / 1ps
`default_nettype none
package rspl_pkg;

   localparam int DEF_STORE_DEPTH = 65536;
   localparam int DEF_SAMPLE_BITS = 16;

   localparam int GAIN_BITS  = 16;
   localparam int START_BITS = 16;
   localparam int RATE_BITS  = 18;
   localparam int COEF_BITS  = 17;
   localparam int CSR_BITS   = 18;
   localparam int FRAC_BITS  = 16;
   localparam int GAIN_SHIFT = 20;

   localparam logic [RATE_BITS-1:0] RATE_MIN = 18'd32768;
   localparam logic [RATE_BITS-1:0] RATE_MAX = 18'd131072;
   localparam logic [COEF_BITS-1:0] COEF_ONE = 17'd65536;

   typedef enum logic [1:0] {
      OP_APPEND  = 2'd0,
      OP_CLEAR   = 2'd1,
      OP_TRIGGER = 2'd2,
      OP_TICK    = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      CSR_GAIN  = 2'd0,
      CSR_START = 2'd1,
      CSR_RATE  = 2'd2,
      CSR_COEF  = 2'd3
   } csr_type;

   typedef struct packed {
      logic do_append;
      logic do_clear;
      logic do_trigger;
      logic rd_first;
      logic rd_second;
      logic calc_interp;
      logic calc_gain;
      logic calc_filt;
      logic load_rsp;
      logic render;
   } cmd_type;

   typedef struct packed {
      logic can_render;
   } status_type;

endpackage
`default_nettype wire

/* rtl/rspl_ctrl.sv */
// sequencer for the sample player: word handshakes and datapath commands
`timescale 1ns / 1ps
`default_nettype none
module rspl_ctrl
   import rspl_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [1:0] req_op,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   input  wire status_type status,
   output cmd_type         cmd
);

   typedef enum logic [2:0] {
      IDLE, RD0, RD1, INTERP, GAIN, FILT, DONE
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      rend_ff;
   logic      accept;
   logic      out_free;
   logic      tick;

   assign accept   = (state_ff == IDLE) && req_valid;
   assign tick     = (op_type'(req_op) == OP_TICK);
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      cmd             = '0;
      cmd.do_append   = accept && (op_type'(req_op) == OP_APPEND);
      cmd.do_clear    = accept && (op_type'(req_op) == OP_CLEAR);
      cmd.do_trigger  = accept && (op_type'(req_op) == OP_TRIGGER);
      cmd.rd_first    = (state_ff == RD0);
      cmd.rd_second   = (state_ff == RD1);
      cmd.calc_interp = (state_ff == INTERP);
      cmd.calc_gain   = (state_ff == GAIN);
      cmd.calc_filt   = (state_ff == FILT);
      cmd.load_rsp    = (state_ff == DONE) && out_free;
      cmd.render      = rend_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
         rend_ff      <= 1'b0;
      end else begin
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            IDLE: begin
               if (req_valid && tick) begin
                  rend_ff  <= status.can_render;
                  state_ff <= status.can_render ? RD0 : DONE;
               end
            end
            RD0:    state_ff <= RD1;
            RD1:    state_ff <= INTERP;
            INTERP: state_ff <= GAIN;
            GAIN:   state_ff <= FILT;
            FILT:   state_ff <= DONE;
            DONE: begin
               if (out_free) begin
                  state_ff <= IDLE;
               end
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

   assign req_ready = (state_ff == IDLE);
   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   a_tick_render: assert property (@(posedge clock) disable iff (reset)
      (accept && tick && status.can_render) |=> (state_ff == RD0 && rend_ff))
      else $error("rendering tick did not start the read sequence");

   a_tick_idle: assert property (@(posedge clock) disable iff (reset)
      (accept && tick && !status.can_render) |=> (state_ff == DONE && !rend_ff))
      else $error("silent tick did not go straight to the result");

   a_done_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == DONE && rsp_valid_ff && !rsp_ready) |=> (state_ff == DONE))
      else $error("result dropped while the output word was still pending");
`endif

endmodule
`default_nettype wire

/* rtl/rspl_datapath.sv */
// sample store, position, interpolation, gain, lowpass and output registers
`timescale 1ns / 1ps
`default_nettype none
module rspl_datapath
   import rspl_pkg::*;
#(
   parameter int STORE_DEPTH = DEF_STORE_DEPTH,
   parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire cmd_type                       cmd,
   output status_type                         status,
   input  wire logic signed [SAMPLE_BITS-1:0] req_sample_value,
   input  wire logic                          csr_we,
   input  wire logic [1:0]                    csr_addr,
   input  wire logic [CSR_BITS-1:0]           csr_wdata,
   output logic signed [SAMPLE_BITS-1:0]      rsp_out_sample,
   output logic                               rsp_playing
);

   localparam int LEN_BITS  = $clog2(STORE_DEPTH + 1);
   localparam int ADDR_BITS = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int IDX_BITS  = LEN_BITS + 1;
   localparam int POS_BITS  = IDX_BITS + FRAC_BITS;
   localparam int FM_BITS   = SAMPLE_BITS + 8;
   localparam int IW        = SAMPLE_BITS + FRAC_BITS + 2;
   localparam int GW        = IW + GAIN_BITS + 1;
   localparam int FW        = COEF_BITS + 1 + FM_BITS + 1;
   localparam int CW        = (LEN_BITS > START_BITS) ? LEN_BITS : START_BITS;
   localparam logic [LEN_BITS-1:0] DEPTH_LEN = LEN_BITS'(STORE_DEPTH);

   logic signed [SAMPLE_BITS-1:0] store [STORE_DEPTH];

   logic [GAIN_BITS-1:0]  gain_ff;
   logic [START_BITS-1:0] start_ff;
   logic [RATE_BITS-1:0]  rate_ff;
   logic [COEF_BITS-1:0]  coef_ff;

   logic [LEN_BITS-1:0]         len_ff;
   logic [POS_BITS-1:0]         pos_ff;
   logic [LEN_BITS-1:0]         count_ff;
   logic signed [FM_BITS-1:0]   fm_ff;
   logic                        stopped_ff;
   logic signed [SAMPLE_BITS-1:0] rd_data_ff;
   logic signed [SAMPLE_BITS-1:0] s0_ff;
   logic signed [IW-1:0]        interp_ff;
   logic signed [FM_BITS-1:0]   xg_ff;
   logic signed [SAMPLE_BITS-1:0] out_ff;
   logic                        playing_ff;

   logic [LEN_BITS-1:0]   len_m1;
   logic [IDX_BITS-1:0]   idx;
   logic [IDX_BITS-1:0]   i1_raw;
   logic [LEN_BITS-1:0]   i0;
   logic [LEN_BITS-1:0]   i1;
   logic [ADDR_BITS-1:0]  rd_addr;
   logic [CW-1:0]         st_w;
   logic [CW-1:0]         lm1_w;
   logic [CW-1:0]         st_cl;
   logic [RATE_BITS-1:0]  rate_cl;
   logic [COEF_BITS-1:0]  coef_cl;
   logic [POS_BITS-1:0]   pos_in;
   logic                  playing;

   logic signed [SAMPLE_BITS:0]   diff;
   logic signed [IW-1:0]          fprod;
   logic signed [IW-1:0]          interp_in;
   logic signed [GW-1:0]          gprod;
   logic signed [GW-GAIN_SHIFT-1:0] gsh;
   logic [GW-GAIN_SHIFT-FM_BITS:0]  gup;
   logic signed [FM_BITS-1:0]     xg_in;
   logic signed [FM_BITS:0]       fdiff;
   logic signed [FW-1:0]          filt_prod;
   logic signed [FW-FRAC_BITS-1:0] filt_sh;
   logic signed [FM_BITS:0]       y_full;
   logic signed [FM_BITS:0]       rnd;
   logic signed [SAMPLE_BITS:0]   rsh;
   logic signed [SAMPLE_BITS-1:0] out_in;

   // read index and clamps
   always_comb begin
      len_m1  = len_ff - LEN_BITS'(1);
      idx     = pos_ff[POS_BITS-1:FRAC_BITS];
      i0      = (idx >= {1'b0, len_ff}) ? len_m1 : idx[LEN_BITS-1:0];
      i1_raw  = {1'b0, i0} + IDX_BITS'(1);
      i1      = (i1_raw >= {1'b0, len_ff}) ? len_m1 : i1_raw[LEN_BITS-1:0];
      rd_addr = cmd.rd_second ? i1[ADDR_BITS-1:0] : i0[ADDR_BITS-1:0];
      st_w    = CW'(start_ff);
      lm1_w   = CW'(len_m1);
      st_cl   = (st_w > lm1_w) ? lm1_w : st_w;
      if (rate_ff < RATE_MIN) begin
         rate_cl = RATE_MIN;
      end else if (rate_ff > RATE_MAX) begin
         rate_cl = RATE_MAX;
      end else begin
         rate_cl = rate_ff;
      end
      coef_cl = (coef_ff > COEF_ONE) ? COEF_ONE : coef_ff;
      pos_in  = pos_ff + POS_BITS'(rate_cl);
      playing = (count_ff < len_ff);
   end

   // arithmetic
   always_comb begin
      diff      = {rd_data_ff[SAMPLE_BITS-1], rd_data_ff} - {s0_ff[SAMPLE_BITS-1], s0_ff};
      fprod     = $signed({1'b0, pos_ff[FRAC_BITS-1:0]}) * diff;
      interp_in = $signed({{2{s0_ff[SAMPLE_BITS-1]}}, s0_ff, {FRAC_BITS{1'b0}}}) + fprod;

      gprod = interp_ff * $signed({1'b0, gain_ff});
      gsh   = gprod[GW-1:GAIN_SHIFT];
      gup   = gsh[GW-GAIN_SHIFT-1:FM_BITS-1];
      if ((&gup) || !(|gup)) begin
         xg_in = gsh[FM_BITS-1:0];
      end else begin
         xg_in = {gsh[GW-GAIN_SHIFT-1], {(FM_BITS-1){~gsh[GW-GAIN_SHIFT-1]}}};
      end

      // fm + a*(x - fm)/2^16 equals the two-weight form exactly
      fdiff     = {xg_ff[FM_BITS-1], xg_ff} - {fm_ff[FM_BITS-1], fm_ff};
      filt_prod = $signed({1'b0, coef_cl}) * fdiff;
      filt_sh   = filt_prod[FW-1:FRAC_BITS];
      y_full    = {fm_ff[FM_BITS-1], fm_ff} + filt_sh[FM_BITS:0];

      rnd = {fm_ff[FM_BITS-1], fm_ff} + (FM_BITS+1)'(128);
      rsh = rnd[FM_BITS:8];
      if (rsh[SAMPLE_BITS] == rsh[SAMPLE_BITS-1]) begin
         out_in = rsh[SAMPLE_BITS-1:0];
      end else begin
         out_in = {rsh[SAMPLE_BITS], {(SAMPLE_BITS-1){~rsh[SAMPLE_BITS]}}};
      end
   end

   // sample memory
   always_ff @(posedge clock) begin
      if (cmd.do_append && (len_ff < DEPTH_LEN)) begin
         store[len_ff[ADDR_BITS-1:0]] <= req_sample_value;
      end
      if (cmd.rd_first || cmd.rd_second) begin
         rd_data_ff <= store[rd_addr];
      end
   end

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff  <= GAIN_BITS'(4096);
         start_ff <= '0;
         rate_ff  <= RATE_BITS'(65536);
         coef_ff  <= COEF_ONE;
      end else if (csr_we) begin
         unique case (csr_type'(csr_addr))
            CSR_GAIN:  gain_ff  <= csr_wdata[GAIN_BITS-1:0];
            CSR_START: start_ff <= csr_wdata[START_BITS-1:0];
            CSR_RATE:  rate_ff  <= csr_wdata[RATE_BITS-1:0];
            CSR_COEF:  coef_ff  <= csr_wdata[COEF_BITS-1:0];
         endcase
      end
   end

   // render state
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff     <= '0;
         pos_ff     <= '0;
         count_ff   <= '0;
         fm_ff      <= '0;
         stopped_ff <= 1'b1;
      end else begin
         if (cmd.do_append && (len_ff < DEPTH_LEN)) begin
            len_ff <= len_ff + LEN_BITS'(1);
         end
         if (cmd.do_clear) begin
            len_ff     <= '0;
            pos_ff     <= '0;
            count_ff   <= '0;
            fm_ff      <= '0;
            stopped_ff <= 1'b1;
         end
         if (cmd.do_trigger && (len_ff != '0)) begin
            pos_ff     <= {IDX_BITS'(st_cl[LEN_BITS-1:0]), {FRAC_BITS{1'b0}}};
            count_ff   <= '0;
            fm_ff      <= '0;
            stopped_ff <= 1'b0;
         end
         if (cmd.calc_filt) begin
            fm_ff      <= y_full[FM_BITS-1:0];
            pos_ff     <= pos_in;
            stopped_ff <= (pos_in >= {1'b0, len_ff, {FRAC_BITS{1'b0}}});
         end
         if (cmd.load_rsp && playing) begin
            count_ff <= count_ff + LEN_BITS'(1);
         end
      end
   end

   // pipeline and output words
   always_ff @(posedge clock) begin
      if (cmd.rd_second) begin
         s0_ff <= rd_data_ff;
      end
      if (cmd.calc_interp) begin
         interp_ff <= interp_in;
      end
      if (cmd.calc_gain) begin
         xg_ff <= xg_in;
      end
      if (cmd.load_rsp) begin
         out_ff     <= cmd.render ? out_in : '0;
         playing_ff <= playing;
      end
   end

   assign status.can_render = playing && !stopped_ff;
   assign rsp_out_sample    = out_ff;
   assign rsp_playing       = playing_ff;

endmodule
`default_nettype wire

/* rtl/resampling_sample_player_lpf.sv */
// top level of the resampling sample player with one-pole lowpass
//
//  channel | ports                                 | direction
//  req     | req_valid req_ready req_op            | in, one op word per handshake
//          | req_sample_value                      |
//  rsp     | rsp_valid rsp_ready rsp_out_sample    | out, one word per tick op
//          | rsp_playing                           |
//  csr     | csr_we csr_addr csr_wdata             | in, write only
//
// append, clear and trigger words are acted on as they are accepted; the sequencer stays idle.
// a rendering tick steps through two reads of the single-port store,
// then interpolate, gain and filter multiplies in turn, then the result; a silent tick goes straight to the result.
// reset is synchronous; the store keeps no reset and needs no clearing pass.
// a pending result stalls the next tick only in its final step.
`timescale 1ns / 1ps
`default_nettype none
module resampling_sample_player_lpf
   import rspl_pkg::*;
#(
   parameter int STORE_DEPTH = DEF_STORE_DEPTH,
   parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [1:0]                    req_op,
   input  wire logic signed [SAMPLE_BITS-1:0] req_sample_value,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic signed [SAMPLE_BITS-1:0]      rsp_out_sample,
   output logic                               rsp_playing,
   input  wire logic                          csr_we,
   input  wire logic [1:0]                    csr_addr,
   input  wire logic [CSR_BITS-1:0]           csr_wdata
);

   cmd_type    cmd;
   status_type status;

   rspl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_op    (req_op),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   rspl_datapath #(
      .STORE_DEPTH (STORE_DEPTH),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_sample_value (req_sample_value),
      .csr_we           (csr_we),
      .csr_addr         (csr_addr),
      .csr_wdata        (csr_wdata),
      .rsp_out_sample   (rsp_out_sample),
      .rsp_playing      (rsp_playing)
   );

endmodule
`default_nettype wire

/* tb/resampling_sample_player_lpf_tb.sv */
// testbench for the resampling sample player: random op words checked against a local predictor
`timescale 1ns / 1ps
module resampling_sample_player_lpf_tb;
   import rspl_pkg::*;

   localparam int STORE_DEPTH   = DEF_STORE_DEPTH;
   localparam int OUT_BITS      = DEF_SAMPLE_BITS;
   localparam int FM_BITS       = DEF_SAMPLE_BITS + 8;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int SETTLE_CYCLES = 12;
   localparam int RANDOM_WORDS  = 1000;

   typedef struct {
      logic signed [OUT_BITS-1:0] out_sample;
      logic                       playing;
   } tick_word_type;

   logic                       clock            = 1'b0;
   logic                       reset            = 1'b1;
   logic                       req_valid        = 1'b0;
   logic                       req_ready;
   logic [1:0]                 req_op           = OP_APPEND;
   logic signed [OUT_BITS-1:0] req_sample_value = '0;
   logic                       rsp_valid;
   logic                       rsp_ready        = 1'b0;
   logic signed [OUT_BITS-1:0] rsp_out_sample;
   logic                       rsp_playing;
   logic                       csr_we           = 1'b0;
   logic [1:0]                 csr_addr         = CSR_GAIN;
   logic [CSR_BITS-1:0]        csr_wdata        = '0;

   // predictor state
   logic signed [OUT_BITS-1:0] store_copy [STORE_DEPTH];
   int unsigned                store_len   = 0;
   longint                     play_pos    = 0;
   int unsigned                out_count   = 0;
   longint                     filt_mem    = 0;
   bit                         render_done = 1'b1;
   logic [GAIN_BITS-1:0]       cfg_gain    = 16'd4096;
   logic [START_BITS-1:0]      cfg_start   = '0;
   logic [RATE_BITS-1:0]       cfg_rate    = 18'd65536;
   logic [COEF_BITS-1:0]       cfg_coef    = COEF_ONE;

   tick_word_type tick_results[$];
   tick_word_type want;
   int unsigned error_count = 0;
   int unsigned cycle_count = 0;
   int unsigned words_sent  = 0;
   int unsigned hold_cycles = 0;
   bit          send_idle   = 1'b0;
   bit          recv_idle   = 1'b0;

   resampling_sample_player_lpf dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_op           (req_op),
      .req_sample_value (req_sample_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_sample   (rsp_out_sample),
      .rsp_playing      (rsp_playing),
      .csr_we           (csr_we),
      .csr_addr         (csr_addr),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   function automatic longint clip(longint x, int bits);
      longint hi;
      hi = (longint'(1) <<< (bits - 1)) - 1;
      if (x > hi) return hi;
      if (x < -hi - 1) return -hi - 1;
      return x;
   endfunction

   // interpolate, apply gain, run the lowpass; updates filt_mem
   function automatic longint render_sample();
      longint i0, i1, frac, s0, s1, interp, gain, coef, mix;
      i0 = play_pos >>> FRAC_BITS;
      if (i0 >= store_len) i0 = store_len - 1;
      i1 = i0 + 1;
      if (i1 >= store_len) i1 = store_len - 1;
      s0 = store_copy[i0];
      s1 = store_copy[i1];
      frac = play_pos & 64'hFFFF;
      gain = cfg_gain;
      coef = (cfg_coef > COEF_ONE) ? COEF_ONE : cfg_coef;
      interp = s0 * 65536 + frac * (s1 - s0);
      mix = clip((interp * gain) >>> GAIN_SHIFT, FM_BITS);
      filt_mem = clip((coef * mix + (65536 - coef) * filt_mem) >>> 16, FM_BITS);
      return clip((filt_mem + 128) >>> 8, OUT_BITS);
   endfunction

   task automatic player_step(op_type op, logic signed [OUT_BITS-1:0] value);
      tick_word_type word;
      longint        st, rate;
      case (op)
         OP_APPEND: begin
            if (store_len < STORE_DEPTH) begin
               store_copy[store_len] = value;
               store_len++;
            end
         end
         OP_CLEAR: begin
            store_len = 0;
            play_pos = 0;
            out_count = 0;
            filt_mem = 0;
            render_done = 1'b1;
         end
         OP_TRIGGER: begin
            if (store_len != 0) begin
               st = cfg_start;
               if (st > store_len - 1) st = store_len - 1;
               play_pos = st << FRAC_BITS;
               out_count = 0;
               filt_mem = 0;
               render_done = 1'b0;
            end
         end
         OP_TICK: begin
            word.out_sample = '0;
            word.playing = 1'b0;
            if (out_count < store_len) begin
               if (!render_done) begin
                  rate = cfg_rate;
                  if (rate < RATE_MIN) rate = RATE_MIN;
                  if (rate > RATE_MAX) rate = RATE_MAX;
                  word.out_sample = OUT_BITS'(render_sample());
                  play_pos += rate;
                  if (play_pos >= (longint'(store_len) << FRAC_BITS)) render_done = 1'b1;
               end
               out_count++;
               word.playing = 1'b1;
            end
            tick_results.push_back(word);
         end
      endcase
   endtask

   task automatic report_mismatch(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      error_count++;
   endtask

   // entered and left at a falling edge
   task automatic send_word(op_type op, logic signed [OUT_BITS-1:0] value);
      int unsigned gap;
      gap = send_idle ? $urandom_range(0, 7) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_sample_value <= value;
      do @(posedge clock); while (!req_ready);
      player_step(op, value);
      words_sent++;
      @(negedge clock);
   endtask

   task automatic write_csr(csr_type idx, logic [CSR_BITS-1:0] value);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
      case (idx)
         CSR_GAIN:  cfg_gain = value[GAIN_BITS-1:0];
         CSR_START: cfg_start = value[START_BITS-1:0];
         CSR_RATE:  cfg_rate = value[RATE_BITS-1:0];
         CSR_COEF:  cfg_coef = value[COEF_BITS-1:0];
      endcase
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (tick_results.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // result side: random stalls, plus a long hold-off on request
   initial begin : sink
      int unsigned stall;
      @(negedge clock);
      forever begin
         stall = recv_idle ? $urandom_range(0, 7) : 0;
         if (hold_cycles != 0) begin
            stall = hold_cycles;
            hold_cycles = 0;
         end
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid || reset);
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (tick_results.size() == 0) begin
            report_mismatch($sformatf("word with none expected, out_sample %0d playing %0b",
                                      rsp_out_sample, rsp_playing));
         end else begin
            want = tick_results.pop_front();
            if (rsp_out_sample !== want.out_sample)
               report_mismatch($sformatf("out_sample got %0d expected %0d",
                                         rsp_out_sample, want.out_sample));
            if (rsp_playing !== want.playing)
               report_mismatch($sformatf("playing got %0b expected %0b",
                                         rsp_playing, want.playing));
         end
      end
   end

   task automatic test_empty_store();
      send_word(OP_TICK, '0);
      send_word(OP_TRIGGER, 16'sh7FFF);
      send_word(OP_TICK, '1);
      settle();
   endtask

   // appended samples without a trigger play as silence
   task automatic test_untriggered_play();
      send_word(OP_APPEND, 16'sh7FFF);
      send_word(OP_APPEND, 16'sh8000);
      repeat (3) send_word(OP_TICK, '0);
      settle();
   endtask

   task automatic test_extreme_render();
      write_csr(CSR_GAIN, 18'd65535);
      write_csr(CSR_COEF, CSR_BITS'(COEF_ONE));
      write_csr(CSR_RATE, 18'd65536);
      send_word(OP_TRIGGER, '0);
      repeat (3) send_word(OP_TICK, '0);
      send_word(OP_CLEAR, '1);
      send_word(OP_TICK, '0);
      settle();
   endtask

   task automatic test_start_clamp();
      write_csr(CSR_GAIN, 18'd4096);
      write_csr(CSR_START, 18'd65535);
      send_word(OP_APPEND, 16'sh0123);
      send_word(OP_APPEND, -16'sh0456);
      send_word(OP_APPEND, 16'sh2000);
      send_word(OP_TRIGGER, '0);
      repeat (4) send_word(OP_TICK, '0);
      settle();
   endtask

   // receiver holds off while ticks keep coming, so the input stalls
   task automatic test_output_stall();
      write_csr(CSR_START, '0);
      write_csr(CSR_RATE, 18'd32768);
      write_csr(CSR_COEF, 18'd20000);
      send_idle = 1'b0;
      recv_idle = 1'b0;
      send_word(OP_CLEAR, '0);
      repeat (6) send_word(OP_APPEND, 16'($urandom));
      send_word(OP_TRIGGER, '0);
      hold_cycles = 300;
      repeat (16) send_word(OP_TICK, '0);
      settle();
   endtask

   task automatic test_random_play();
      int unsigned first, len;
      logic [CSR_BITS-1:0] gain, start, rate, coef;
      first = words_sent;
      while (words_sent - first < RANDOM_WORDS) begin
         send_idle = $urandom_range(0, 3) != 0;
         recv_idle = $urandom_range(0, 3) != 0;
         if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 3))
               0: gain = '0;
               1: gain = 18'd65535;
               2: gain = CSR_BITS'($urandom_range(0, 8191));
               default: gain = CSR_BITS'($urandom_range(0, 65535));
            endcase
            case ($urandom_range(0, 3))
               0: start = '0;
               1: start = 18'd65535;
               default: start = CSR_BITS'($urandom_range(0, 15));
            endcase
            case ($urandom_range(0, 3))
               0: rate = RATE_MIN;
               1: rate = RATE_MAX;
               2: rate = CSR_BITS'($urandom_range(0, 18'h3FFFF));
               default: rate = CSR_BITS'($urandom_range(RATE_MIN, RATE_MAX));
            endcase
            case ($urandom_range(0, 3))
               0: coef = '0;
               1: coef = CSR_BITS'(COEF_ONE);
               2: coef = CSR_BITS'($urandom_range(0, 17'h1FFFF));
               default: coef = CSR_BITS'($urandom_range(0, COEF_ONE));
            endcase
            settle();
            write_csr(CSR_GAIN, gain);
            write_csr(CSR_START, start);
            write_csr(CSR_RATE, rate);
            write_csr(CSR_COEF, coef);
         end
         if ($urandom_range(0, 6) == 0) begin
            repeat ($urandom_range(1, 8))
               send_word(op_type'($urandom_range(0, 3)), 16'($urandom));
         end else begin
            if ($urandom_range(0, 4) != 0) send_word(OP_CLEAR, 16'($urandom));
            len = $urandom_range(1, 12);
            repeat (len) send_word(OP_APPEND, 16'($urandom));
            send_word(OP_TRIGGER, 16'($urandom));
            repeat (len + $urandom_range(0, 3)) send_word(OP_TICK, 16'($urandom));
         end
      end
      settle();
   endtask

   initial begin
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_empty_store();
      test_untriggered_play();
      test_extreme_render();
      test_start_clamp();
      test_output_stall();
      test_random_play();
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/rspl_pkg.sv
rtl/rspl_ctrl.sv
rtl/rspl_datapath.sv
rtl/resampling_sample_player_lpf.sv
tb/resampling_sample_player_lpf_tb.sv
